### rtl/core/wef32_pkg.sv
// Package for the weight element to single-precision converter.
// Holds element type codes, field widths and the conversion functions.
// No dependencies.
`timescale 1ns / 1ps

package wef32_pkg;

  localparam int TypeWidth = 3;
  localparam int DataWidth = 32;

  localparam logic [TypeWidth-1:0] TYPE_HALF   = 3'd0;
  localparam logic [TypeWidth-1:0] TYPE_BF16   = 3'd1;
  localparam logic [TypeWidth-1:0] TYPE_INT8   = 3'd2;
  localparam logic [TypeWidth-1:0] TYPE_INT32  = 3'd3;
  localparam logic [TypeWidth-1:0] TYPE_SINGLE = 3'd4;

  localparam logic [7:0] HalfBiasAdj = 8'd112;  // 127 - 15

  typedef struct packed {
    logic [31:0] bits;
    logic        not_finite;
  } result_t;

  // Position of the leading one in a 32-bit word; 0 for a zero word.
  function automatic logic [4:0] lead_one(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [9:0]  man;
    logic [4:0]  ex;
    logic [4:0]  p;
    logic [9:0]  norm;
    logic [31:0] r;
    man = h[9:0];
    ex  = h[14:10];
    p   = lead_one({22'd0, man});
    norm = 10'({man, 10'd0} >> p);
    r = {h[15], 31'd0};
    if (ex == 5'd0) begin
      if (man != 10'd0) begin
        // Subnormal: leading one at bit p gives exponent 103 + p.
        r[30:23] = 8'd103 + {3'd0, p};
        r[22:13] = norm;
      end
    end else if (ex == 5'h1f) begin
      r[30:23] = 8'hff;
      r[22:13] = man;
    end else begin
      r[30:23] = {3'd0, ex} + HalfBiasAdj;
      r[22:13] = man;
    end
    return r;
  endfunction

  // Magnitude 0 .. 2^31 with sign to single, round to nearest even.
  function automatic logic [31:0] int_to_single(input logic neg, input logic [31:0] mag);
    logic [4:0]  p;
    logic [31:0] al;
    logic [23:0] man;
    logic        g;
    logic        st;
    logic [24:0] rnd;
    logic [7:0]  ex;
    if (mag == 32'd0) return 32'd0;
    p  = lead_one(mag);
    al = mag << (5'd31 - p);  // leading one at bit 31
    man = al[31:8];
    g   = al[7];
    st  = |al[6:0];
    rnd = {1'b0, man} + {24'd0, g & (st | man[0])};
    ex  = 8'd127 + {3'd0, p};
    if (rnd[24]) begin
      ex = ex + 8'd1;
      return {neg, ex, 23'd0};
    end
    return {neg, ex, rnd[22:0]};
  endfunction

endpackage

### rtl/core/wef32_conv.sv
// Combinational element conversion for one item.
// Depends on wef32_pkg.
`timescale 1ns / 1ps

module wef32_conv (
  input  logic [wef32_pkg::TypeWidth-1:0] element_type,
  input  logic [31:0]                     raw,
  output wef32_pkg::result_t              res
);

  logic [31:0] bits;
  logic        bad;
  logic [7:0]  b;

  always_comb begin
    bits = 32'd0;
    bad  = 1'b0;
    b    = raw[7:0];
    case (element_type)
      wef32_pkg::TYPE_HALF:   bits = wef32_pkg::half_to_single(raw[15:0]);
      wef32_pkg::TYPE_BF16:   bits = {raw[15:0], 16'd0};
      wef32_pkg::TYPE_INT8:   bits = wef32_pkg::int_to_single(b[7],
                                32'(b[7] ? (9'h100 - {1'b0, b}) : {1'b0, b}));
      wef32_pkg::TYPE_INT32:  bits = wef32_pkg::int_to_single(raw[31],
                                raw[31] ? (32'd0 - raw) : raw);
      wef32_pkg::TYPE_SINGLE: bits = raw;
      default:                bad  = 1'b1;
    endcase
    res.bits       = bits;
    res.not_finite = bad | (&bits[30:23]);
  end

endmodule

### rtl/core/weight_element_to_fp32.sv
// Top level of the weight element to single-precision converter.
// Depends on wef32_pkg and wef32_conv.
`timescale 1ns / 1ps

// Channel | Dir | Bits
// s_axis  | in  | tdata[31:0] raw_element
// m_axis  | out | tdata[31:0] single_bits, tuser[0] not_finite
// cfg     | in  | cfg_we, cfg_wdata[2:0] element_type
// An item is registered at input, converted in one pass and registered at output;
// one item per cycle is sustained while the output is not stalled.
// Reset clears both stage valid bits and sets the type to half float.
// A stall at the output holds both stages; the input stage may still refill
// when it is empty or moving.

module weight_element_to_fp32 (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // raw_element
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // single_bits
  output logic [0:0]  m_axis_tuser    // not_finite
);

  logic [2:0]  element_type;
  logic        in_valid;
  logic [31:0] in_raw;
  logic        out_valid;
  wef32_pkg::result_t out_res;
  wef32_pkg::result_t conv_res;
  logic        out_load;

  assign out_load      = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || out_load;

  wef32_conv u_conv (
    .element_type (element_type),
    .raw          (in_raw),
    .res          (conv_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      element_type <= wef32_pkg::TYPE_HALF;
      in_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) element_type <= cfg_wdata;
      if (s_axis_tready) in_valid <= s_axis_tvalid;
      if (out_load) out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) in_raw <= s_axis_tdata;
    if (out_load && in_valid) out_res <= conv_res;
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_res.bits;
  assign m_axis_tuser[0] = out_res.not_finite;

  a_int_finite: assert property (@(posedge clk) disable iff (rst)
    (out_load && in_valid && (element_type == wef32_pkg::TYPE_INT8 ||
     element_type == wef32_pkg::TYPE_INT32)) |=> !m_axis_tuser[0])
    else $error("integer result flagged not finite");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_flow: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_load) |=> in_valid)
    else $error("input stage item lost");

endmodule
